[design/dqvd_pkg.sv]
// ----------------------------------------------------------------------------
// dqvd_pkg
// Shared constants, command and status codes, and the control and status
// bundles that pass between the deque controller and its datapath.
// ----------------------------------------------------------------------------
package dqvd_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_PEEK_FRONT = 3'd3,
    CMD_DELETE     = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ZERO  = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic latch_in;
    logic exec_go;
    logic scan_step;
    logic done_go;
  } dqvd_ctrl_t;

  typedef struct packed {
    logic needs_scan;
    logic scan_last;
  } dqvd_stat_t;

endpackage

[design/dqvd_ctrl.sv]
// ----------------------------------------------------------------------------
// dqvd_ctrl
// Controller state machine: takes one transfer at a time, sequences the
// single-step commands and the delete scan, and owns the result handshake.
// ----------------------------------------------------------------------------
module dqvd_ctrl
  import dqvd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dqvd_stat_t stat_i,
  output dqvd_ctrl_t ctrl_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    ctrl_o = '0;
    case (state_q)
      S_IDLE: ctrl_o.latch_in  = in_valid_i;
      S_EXEC: ctrl_o.exec_go   = !stat_i.needs_scan && out_free;
      S_SCAN: ctrl_o.scan_step = 1'b1;
      S_DONE: ctrl_o.done_go   = out_free;
      default: ctrl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (stat_i.needs_scan) state_q <= S_SCAN;
          else if (out_free) state_q <= S_IDLE;
        end
        S_SCAN: begin
          if (stat_i.scan_last) state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (ctrl_o.exec_go || ctrl_o.done_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[design/dqvd_datapath.sv]
// ----------------------------------------------------------------------------
// dqvd_datapath
// Ring memory with one write and one registered read port, head and count
// registers, the delete scan pointers and the result register.
// ----------------------------------------------------------------------------
module dqvd_datapath
  import dqvd_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dqvd_ctrl_t          ctrl_i,
  output dqvd_stat_t          stat_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [VALUE_W-1:0]  value_i,
  output logic [VALUE_W-1:0]  read_value_o,
  output logic                found_o,
  output logic [COUNT_W-1:0]  removed_count_o,
  output logic [COUNT_W-1:0]  occupancy_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                         input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(DEPTH)) sum = sum - (CNT_W + 1)'(DEPTH);
    return AW'(sum);
  endfunction

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;

  logic [CMD_W-1:0]      cmd_q;
  logic [DATA_WIDTH-1:0] word_q;
  logic [AW-1:0]         head_q, head_d, head_prev, head_next;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      idx_q, idx_d, idx_inc;
  logic [CNT_W-1:0]      kept_q, kept_d;
  logic                  word_zero, is_empty, is_full, mismatch;

  logic [VALUE_W-1:0]    res_value_d, read_value_q;
  logic                  res_found_d, found_q;
  logic [COUNT_W-1:0]    res_removed_d, removed_q;
  logic [COUNT_W-1:0]    res_occ_d, occ_q;
  status_e               res_status_d, status_q;

  assign word_zero = (word_q == '0);
  assign is_empty  = (count_q == '0);
  assign is_full   = (count_q == CNT_W'(DEPTH));
  assign mismatch  = (rdata_q != word_q);
  assign idx_inc   = idx_q + 1'b1;
  assign head_prev = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
  assign head_next = slot(head_q, CNT_W'(1));

  assign stat_o.needs_scan = (cmd_q == CMD_DELETE) && !word_zero && !is_empty;
  assign stat_o.scan_last  = (idx_inc == count_q);

  always_comb begin
    head_d        = head_q;
    count_d       = count_q;
    idx_d         = idx_q;
    kept_d        = kept_q;
    mem_we        = 1'b0;
    mem_waddr     = slot(head_q, kept_q);
    mem_wdata     = rdata_q;
    res_value_d   = '0;
    res_found_d   = 1'b0;
    res_removed_d = '0;
    res_status_d  = ST_OK;

    if (ctrl_i.latch_in) begin
      idx_d  = '0;
      kept_d = '0;
    end

    if (ctrl_i.scan_step) begin
      idx_d = idx_inc;
      if (mismatch) begin
        mem_we = 1'b1;
        kept_d = kept_q + 1'b1;
      end
    end

    if (ctrl_i.exec_go) begin
      case (cmd_q)
        CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
          if (word_zero) begin
            res_status_d = ST_ZERO;
          end else if (is_full) begin
            res_status_d = ST_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = word_q;
            count_d   = count_q + 1'b1;
            if (cmd_q == CMD_PUSH_BACK) begin
              mem_waddr = slot(head_q, count_q);
            end else begin
              mem_waddr = head_prev;
              head_d    = head_prev;
            end
          end
        end
        CMD_POP_FRONT, CMD_PEEK_FRONT: begin
          if (is_empty) begin
            res_status_d = ST_EMPTY;
          end else begin
            res_value_d = VALUE_W'(rdata_q);
            res_found_d = 1'b1;
            if (cmd_q == CMD_POP_FRONT) begin
              head_d  = head_next;
              count_d = count_q - 1'b1;
            end
          end
        end
        CMD_DELETE: begin
          if (word_zero) res_status_d = ST_ZERO;
        end
        default: res_status_d = ST_OK;
      endcase
    end

    if (ctrl_i.done_go) begin
      count_d       = kept_q;
      res_removed_d = COUNT_W'(count_q - kept_q);
    end

    res_occ_d = COUNT_W'(count_d);
    mem_raddr = slot(head_q, idx_d);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
      kept_q  <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      kept_q  <= kept_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_in) begin
      cmd_q  <= command_i;
      word_q <= DATA_WIDTH'(value_i);
    end
    if (ctrl_i.exec_go || ctrl_i.done_go) begin
      read_value_q <= res_value_d;
      found_q      <= res_found_d;
      removed_q    <= res_removed_d;
      occ_q        <= res_occ_d;
      status_q     <= res_status_d;
    end
  end

  assign read_value_o    = read_value_q;
  assign found_o         = found_q;
  assign removed_count_o = removed_q;
  assign occupancy_o     = occ_q;
  assign status_o        = status_q;

endmodule

[design/deque_with_value_delete.sv]
// ----------------------------------------------------------------------------
// deque_with_value_delete
// A bounded double-ended queue of data words with push back, push front,
// pop, peek and delete-all-matching commands, one result per command.
// ----------------------------------------------------------------------------
// The block takes one command at a time. Push, pop, peek, rejected and
// unknown commands, and a delete on an empty queue, go from the idle state
// through the execute state back to idle. A delete of a nonzero word on a
// nonempty queue also passes the scan and done states, since the scan reads
// one entry per cycle and writes each kept entry back into place through the
// write port of the ring memory. A result waiting in the output register
// stalls the next command only at the point where its own result is written.
module deque_with_value_delete
  import dqvd_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [VALUE_W-1:0]  value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [VALUE_W-1:0]  read_value_o,
  output logic                found_o,
  output logic [COUNT_W-1:0]  removed_count_o,
  output logic [COUNT_W-1:0]  occupancy_o,
  output logic [STATUS_W-1:0] status_o
);

  dqvd_ctrl_t ctrl;
  dqvd_stat_t stat;

  dqvd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  dqvd_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .command_i       (command_i),
    .value_i         (value_i),
    .read_value_o    (read_value_o),
    .found_o         (found_o),
    .removed_count_o (removed_count_o),
    .occupancy_o     (occupancy_o),
    .status_o        (status_o)
  );

endmodule

[design/dqvd_checker.sv]
// ----------------------------------------------------------------------------
// dqvd_checker
// Port-level checks for the deque, bound to the top level.
// ----------------------------------------------------------------------------
module dqvd_checker
  import dqvd_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [VALUE_W-1:0]  read_value_o,
  input logic                found_o,
  input logic [COUNT_W-1:0]  removed_count_o,
  input logic [COUNT_W-1:0]  occupancy_o,
  input logic [STATUS_W-1:0] status_o
);

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input was ready right after a transfer.");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (DEPTH >= 32) || (occupancy_o <= COUNT_W'(DEPTH)))
    else $error("Occupancy exceeds the queue depth.");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == ST_OK && removed_count_o == '0)
    else $error("A returned word came with a bad status or a removal.");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |->
      !found_o && read_value_o == '0 && occupancy_o == '0)
    else $error("An empty-queue result carried data.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o))
    else $error("A stalled result changed or vanished.");

endmodule

bind deque_with_value_delete dqvd_checker #(
  .DEPTH (DEPTH)
) u_dqvd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .read_value_o    (read_value_o),
  .found_o         (found_o),
  .removed_count_o (removed_count_o),
  .occupancy_o     (occupancy_o),
  .status_o        (status_o)
);

[tb/sv/deque_with_value_delete_test.sv]
// ----------------------------------------------------------------------------
// deque_with_value_delete_test
// Self-checking testbench for the deque with push, pop, peek and
// delete-all-matching commands. A directed sequence covers empty, full and
// zero-word cases, then biased random command streams fill, drain and prune
// the queue. Every accepted command is run through a behavioral deque, and
// each result transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module deque_with_value_delete_test;
  import dqvd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 1825;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned REPORT_MAX   = 40;
  localparam longint unsigned TIMEOUT_NS = 64'd10_000_000;

  localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

  localparam int unsigned MODE_FILL  = 0;
  localparam int unsigned MODE_DRAIN = 1;
  localparam int unsigned MODE_PRUNE = 2;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
  } deque_cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               found;
    logic [COUNT_W-1:0] removed_count;
    logic [COUNT_W-1:0] occupancy;
    status_e            status;
  } deque_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [CMD_W-1:0]    command_i = '0;
  logic [VALUE_W-1:0]  value_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [VALUE_W-1:0]  read_value_o;
  logic                found_o;
  logic [COUNT_W-1:0]  removed_count_o;
  logic [COUNT_W-1:0]  occupancy_o;
  logic [STATUS_W-1:0] status_o;

  deque_cmd_t    pending_cmds[$];
  deque_result_t predicted_results[$];

  logic [VALUE_W-1:0] ring_words [DEPTH];
  int unsigned        ring_head = 0;
  int unsigned        ring_count = 0;

  logic        in_xfer = 1'b0;
  int unsigned n_accepted = 0;
  int unsigned n_errors = 0;
  int unsigned send_gap = 0;
  int unsigned ready_gap = 0;
  int unsigned hold_left = 0;
  int unsigned hold_mark = 400;
  logic        calm;

  assign calm = ((n_accepted / 150) % 5) == 4;

  deque_with_value_delete dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_value_o   (read_value_o),
    .found_o        (found_o),
    .removed_count_o(removed_count_o),
    .occupancy_o    (occupancy_o),
    .status_o       (status_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic run_deque_command(input logic [CMD_W-1:0] cmd,
                                   input logic [VALUE_W-1:0] word,
                                   output deque_result_t res);
    int unsigned kept;
    logic [VALUE_W-1:0] entry;
    res = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (word == '0) begin
          res.status = ST_ZERO;
        end else if (ring_count >= DEPTH) begin
          res.status = ST_FULL;
        end else if (cmd == CMD_PUSH_BACK) begin
          ring_words[(ring_head + ring_count) % DEPTH] = word;
          ring_count++;
        end else begin
          ring_head = (ring_head + DEPTH - 1) % DEPTH;
          ring_words[ring_head] = word;
          ring_count++;
        end
      end
      CMD_POP_FRONT, CMD_PEEK_FRONT: begin
        if (ring_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.read_value = ring_words[ring_head];
          res.found = 1'b1;
          if (cmd == CMD_POP_FRONT) begin
            ring_head = (ring_head + 1) % DEPTH;
            ring_count--;
          end
        end
      end
      CMD_DELETE: begin
        if (word == '0) begin
          res.status = ST_ZERO;
        end else begin
          kept = 0;
          for (int unsigned i = 0; i < ring_count; i++) begin
            entry = ring_words[(ring_head + i) % DEPTH];
            if (entry != word) begin
              ring_words[(ring_head + kept) % DEPTH] = entry;
              kept++;
            end
          end
          res.removed_count = COUNT_W'(ring_count - kept);
          ring_count = kept;
        end
      end
      default: begin
      end
    endcase
    res.occupancy = COUNT_W'(ring_count);
  endtask

  function automatic int unsigned pick_gap(input logic no_idle);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return '1;
    if (r < 60) return VALUE_W'($urandom_range(1, 5));
    return $urandom;
  endfunction

  task automatic add_cmd(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value);
    deque_cmd_t item;
    item.cmd = cmd;
    item.value = value;
    pending_cmds.push_back(item);
  endtask

  task automatic report_mismatch(input string field, input logic [VALUE_W-1:0] want,
                                 input logic [VALUE_W-1:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    n_errors++;
  endtask

  // Command driver.
  always @(negedge clk_i) begin
    deque_cmd_t next_cmd;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_xfer) begin
      if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_cmds.size() != 0) begin
        next_cmd = pending_cmds.pop_front();
        command_i <= next_cmd.cmd;
        value_i <= next_cmd.value;
        in_valid_i <= 1'b1;
        send_gap <= pick_gap(calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off after 400 accepted commands and every 900 after that.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (n_accepted >= hold_mark) begin
      out_ready_i <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_mark <= hold_mark + 900;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (ready_gap != 0) begin
      out_ready_i <= 1'b0;
      ready_gap <= ready_gap - 1;
    end else begin
      out_ready_i <= 1'b1;
      ready_gap <= pick_gap(calm);
    end
  end

  // Monitor: predicts on each command transfer and checks each result transfer.
  always @(posedge clk_i) begin
    deque_result_t want;
    deque_result_t got;
    if (!rst_ni) begin
      in_xfer <= 1'b0;
    end else begin
      in_xfer <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        run_deque_command(command_i, value_i, want);
        predicted_results.push_back(want);
        n_accepted <= n_accepted + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (predicted_results.size() == 0) begin
          if (n_errors < REPORT_MAX)
            $display("%0t: result transfer with no command outstanding", $time);
          n_errors++;
        end else begin
          want = predicted_results.pop_front();
          got.read_value = read_value_o;
          got.found = found_o;
          got.removed_count = removed_count_o;
          got.occupancy = occupancy_o;
          got.status = status_e'(status_o);
          if (got.read_value !== want.read_value)
            report_mismatch("read_value", want.read_value, got.read_value);
          if (got.found !== want.found)
            report_mismatch("found", VALUE_W'(want.found), VALUE_W'(got.found));
          if (got.removed_count !== want.removed_count)
            report_mismatch("removed_count", VALUE_W'(want.removed_count),
                            VALUE_W'(got.removed_count));
          if (got.occupancy !== want.occupancy)
            report_mismatch("occupancy", VALUE_W'(want.occupancy), VALUE_W'(got.occupancy));
          if (got.status !== want.status)
            report_mismatch("status", VALUE_W'(want.status), VALUE_W'(got.status));
        end
      end
    end
  end

  initial begin
    int unsigned n_known;
    int unsigned mode;
    int unsigned len;
    int unsigned r;
    logic [CMD_W-1:0] cmd;

    // Empty queue, zero words and a reserved command.
    add_cmd(CMD_POP_FRONT, '1);
    add_cmd(CMD_PEEK_FRONT, 32'h1234_5678);
    add_cmd(CMD_DELETE, 32'd9);
    add_cmd(CMD_PUSH_BACK, '0);
    add_cmd(CMD_RSVD_HI, '1);
    // Fill to capacity from both ends, half of the entries the same word.
    for (int unsigned i = 0; i < DEPTH; i++) begin
      if (i % 2 == 0) add_cmd(CMD_PUSH_BACK, 32'd5);
      else if (i == 1) add_cmd(CMD_PUSH_FRONT, '1);
      else if (i == 3) add_cmd(CMD_PUSH_FRONT, 32'd1);
      else add_cmd(CMD_PUSH_FRONT, 32'h8000_0000 | i);
    end
    add_cmd(CMD_PUSH_BACK, 32'd3);
    add_cmd(CMD_PUSH_FRONT, '0);
    add_cmd(CMD_DELETE, 32'd5);
    add_cmd(CMD_PEEK_FRONT, '0);
    add_cmd(CMD_POP_FRONT, 32'd7);
    add_cmd(CMD_DELETE, '0);

    n_known = 0;
    while (n_known < RANDOM_ITEMS) begin
      mode = $urandom_range(MODE_FILL, MODE_PRUNE);
      len = $urandom_range(10, 60);
      for (int unsigned j = 0; j < len; j++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          cmd = CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
        end else begin
          r = $urandom_range(0, 99);
          if (mode == MODE_FILL) begin
            if (r < 55) cmd = CMD_PUSH_BACK;
            else if (r < 75) cmd = CMD_PUSH_FRONT;
            else if (r < 85) cmd = CMD_POP_FRONT;
            else if (r < 92) cmd = CMD_PEEK_FRONT;
            else cmd = CMD_DELETE;
          end else if (mode == MODE_DRAIN) begin
            if (r < 15) cmd = CMD_PUSH_BACK;
            else if (r < 25) cmd = CMD_PUSH_FRONT;
            else if (r < 70) cmd = CMD_POP_FRONT;
            else if (r < 85) cmd = CMD_PEEK_FRONT;
            else cmd = CMD_DELETE;
          end else begin
            if (r < 30) cmd = CMD_PUSH_BACK;
            else if (r < 50) cmd = CMD_PUSH_FRONT;
            else if (r < 65) cmd = CMD_POP_FRONT;
            else if (r < 75) cmd = CMD_PEEK_FRONT;
            else cmd = CMD_DELETE;
          end
          n_known++;
        end
        add_cmd(cmd, pick_word());
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid_i) @(posedge clk_i);
    while (predicted_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
design/dqvd_pkg.sv
design/dqvd_ctrl.sv
design/dqvd_datapath.sv
design/deque_with_value_delete.sv
design/dqvd_checker.sv
tb/sv/deque_with_value_delete_test.sv
